FILE: hdl/qkd_pkg.sv
// Shared types, constants and helper functions for the quadrature knob decoder.
package qkd_pkg;

  // Field widths.
  localparam int SAMPLE_W    = 2;
  localparam int THRESHOLD_W = 7;
  localparam int HISTORY_W   = 9;
  localparam int STEP_W      = 2;
  localparam int COUNT_W     = 16;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  // Bit positions of the output fields inside the output tdata.
  localparam int STEP_LSB  = 0;
  localparam int COUNT_LSB = STEP_LSB + STEP_W;

  // Reset values and the default tick counter width.
  localparam int TICK_WIDTH_DEFAULT = 16;
  localparam logic signed [HISTORY_W-1:0] HISTORY_RESET = 9'sd5;
  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 7'd1;

  // Step codes.
  localparam logic signed [STEP_W-1:0] STEP_NONE = 2'sd0;
  localparam logic signed [STEP_W-1:0] STEP_CW   = 2'sd1;
  localparam logic signed [STEP_W-1:0] STEP_CCW  = -2'sd1;

  // Encoder states (A plus 2*B).
  localparam logic [SAMPLE_W-1:0] ST_00 = 2'd0;
  localparam logic [SAMPLE_W-1:0] ST_A  = 2'd1;
  localparam logic [SAMPLE_W-1:0] ST_B  = 2'd2;
  localparam logic [SAMPLE_W-1:0] ST_AB = 2'd3;

  // History direction for a move between two encoder states: one Gray-code
  // ring moves the history down, the opposite ring moves it up, and a jump
  // of two bits leaves it alone.
  function automatic logic signed [1:0] transition_dir(
    input logic [SAMPLE_W-1:0] from_state,
    input logic [SAMPLE_W-1:0] to_state
  );
    logic signed [1:0] dir;
    dir = 2'sd0;
    case ({from_state, to_state})
      {ST_00, ST_B}, {ST_B, ST_AB}, {ST_AB, ST_A}, {ST_A, ST_00}: dir = -2'sd1;
      {ST_00, ST_A}, {ST_A, ST_AB}, {ST_AB, ST_B}, {ST_B, ST_00}: dir = 2'sd1;
      default: dir = 2'sd0;
    endcase
    return dir;
  endfunction

endpackage

FILE: hdl/quadrature_knob_decoder.sv
// Quadrature knob decoder with detent history and a saturating tick counter.
//
//   Channel   Direction  Handshake                 Payload
//   s_axis    in         s_axis_tvalid/tready      first_sample, confirm_sample
//   m_axis    out        m_axis_tvalid/tready      step, tick_count
//   cfg       in         cfg_valid/cfg_ready       step_threshold
//
// One request is accepted every clock cycle unless the output stalls; each result
// passes from the input register through the decode into the result register.
// The decoder state (last state, history, ticks) updates together with the result register.
// Reset empties both stages and restores threshold, history and tick count.
// A stalled output holds its result; the input register still takes one more
// request, after which s_axis_tready drops until the output drains.
module quadrature_knob_decoder #(
  parameter int TICK_WIDTH = qkd_pkg::TICK_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // Input stream.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [1:0] first_sample, [3:2] confirm_sample, [7:4] zero
  input  logic [qkd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Output stream.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] step, [17:2] tick_count, [23:18] zero
  output logic [qkd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Threshold write channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [qkd_pkg::THRESHOLD_W-1:0] cfg_data
);
  import qkd_pkg::*;

  localparam int EXT_W = (TICK_WIDTH < COUNT_W) ? COUNT_W : TICK_WIDTH;
  localparam logic signed [TICK_WIDTH-1:0] TICK_MAX = {1'b0, {(TICK_WIDTH-1){1'b1}}};
  localparam logic signed [TICK_WIDTH-1:0] TICK_MIN = {1'b1, {(TICK_WIDTH-1){1'b0}}};

  // Configuration and decoder state.
  logic [THRESHOLD_W-1:0]       step_threshold;
  logic [SAMPLE_W-1:0]          last_state;
  logic signed [HISTORY_W-1:0]  step_history;
  logic signed [TICK_WIDTH-1:0] ticks;
  logic                         first_event_pending;

  // Input register.
  logic                in_valid;
  logic [SAMPLE_W-1:0] in_first;
  logic [SAMPLE_W-1:0] in_confirm;

  // Result register.
  logic                      out_valid;
  logic signed [STEP_W-1:0]  out_step;
  logic [COUNT_W-1:0]        out_count;

  // Decode signals.
  logic                         advance;
  logic                         moved;
  logic signed [HISTORY_W-1:0]  hist_sum;
  logic signed [HISTORY_W-1:0]  thr_pos;
  logic signed [HISTORY_W-1:0]  step_history_next;
  logic [SAMPLE_W-1:0]          last_state_next;
  logic signed [STEP_W-1:0]     step_next;
  logic signed [TICK_WIDTH-1:0] ticks_next;
  logic [EXT_W-1:0]             ticks_ext;

  assign cfg_ready     = 1'b1;
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  // Decode the registered sample pair against the current state.
  always_comb begin
    moved    = (in_first == in_confirm) && (in_first != last_state);
    thr_pos  = signed'({{(HISTORY_W-THRESHOLD_W){1'b0}}, step_threshold});
    hist_sum = step_history + HISTORY_W'(transition_dir(last_state, in_first));
    step_next         = STEP_NONE;
    step_history_next = step_history;
    last_state_next   = last_state;
    if (moved) begin
      last_state_next   = in_first;
      step_history_next = hist_sum;
      if (hist_sum > thr_pos) begin
        step_next         = STEP_CW;
        step_history_next = '0;
      end else if (hist_sum < -thr_pos) begin
        step_next         = STEP_CCW;
        step_history_next = '0;
      end
    end
  end

  // Steps apply inverted to the saturating tick count, except on the first event.
  always_comb begin
    ticks_next = ticks;
    if (!first_event_pending) begin
      if (step_next == STEP_CCW && ticks != TICK_MAX) begin
        ticks_next = ticks + TICK_WIDTH'(1);
      end else if (step_next == STEP_CW && ticks != TICK_MIN) begin
        ticks_next = ticks - TICK_WIDTH'(1);
      end
    end
    ticks_ext = EXT_W'(ticks_next);
  end

  // Input register: takes a request whenever it is empty or moving on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_first   <= s_axis_tdata[SAMPLE_W-1:0];
      in_confirm <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end
  end

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step_threshold <= cfg_data;
    end
  end

  // Decoder state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid           <= 1'b0;
      last_state          <= ST_00;
      step_history        <= HISTORY_RESET;
      ticks               <= '0;
      first_event_pending <= 1'b1;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        last_state          <= last_state_next;
        step_history        <= step_history_next;
        ticks               <= ticks_next;
        first_event_pending <= 1'b0;
      end
    end
    if (advance && in_valid) begin
      out_step  <= step_next;
      out_count <= ticks_ext[COUNT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-COUNT_W-STEP_W){1'b0}}, out_count, out_step};

endmodule

FILE: hdl/quadrature_knob_decoder_checker.sv
// Port-level checker for the quadrature knob decoder, with its bind statement.
module quadrature_knob_decoder_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [qkd_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import qkd_pkg::*;

  logic [STEP_W-1:0]  step_f;
  logic [COUNT_W-1:0] count_f;

  assign step_f  = m_axis_tdata[COUNT_LSB-1:STEP_LSB];
  assign count_f = m_axis_tdata[COUNT_LSB+COUNT_W-1:COUNT_LSB];

  // Reset leaves both pipeline stages empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("pipeline not empty after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // The step field is never the unused negative code.
  a_step_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (step_f == STEP_NONE || step_f == STEP_CW || step_f == STEP_CCW))
    else $error("invalid step code");

  // A result without a step repeats the tick count of the result before it.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready) ##1 (m_axis_tvalid && step_f == STEP_NONE)
      |-> (count_f == $past(count_f)))
    else $error("tick count moved without a step");

endmodule

bind quadrature_knob_decoder quadrature_knob_decoder_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
